>>> rtl/sfla_pkg.sv
package sfla_pkg;

    localparam int unsigned GRAN_W  = 14;
    localparam int unsigned LINK_W  = 15;
    localparam int unsigned SIZE_W  = 13;
    localparam int unsigned LIMIT_W = 7;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_BAD_SIZE = 2'd1;
    localparam logic [1:0] ST_NO_PAGES = 2'd2;

    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_FREE  = 1'b1;

    typedef struct packed {
        logic              action;
        logic [SIZE_W-1:0] req_size;
        logic [GRAN_W-1:0] free_granule;
    } t_req;

    typedef struct packed {
        logic [GRAN_W-1:0] alloc_granule;
        logic [1:0]        status;
    } t_rsp;

    // one write request to the link store
    typedef struct packed {
        logic              we;
        logic [GRAN_W-1:0] addr;
        logic [LINK_W-1:0] data;
    } t_link_wr;

endpackage

>>> rtl/slab_free_list_allocator_core.sv
// Slab allocator core. Pulse start with a word while busy is low; exactly one
// result word appears on o_rsp for one cycle with o_done, and it cannot be
// stalled. A refused request goes from S_CHECK to S_REPLY, a free through
// S_CHECK, S_HEAD and S_REPLY, and an allocation from a non-empty class through
// S_CHECK, S_HEAD (head lookup), S_LREAD and S_LWAIT (link read through the
// registered link store) and S_REPLY. An allocation that carves a new page
// first walks the page once through the shared address adder in S_CARVE, one
// entry per cycle. Class heads use valid bits cleared at reset, so no clearing
// pass is needed.
module slab_free_list_allocator_core #(
    parameter int unsigned PAGE_BYTES  = 4096,
    parameter int unsigned CLASS_COUNT = 256,
    parameter int unsigned POOL_PAGES  = 64
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  sfla_pkg::t_req                 i_req,
    output logic                           o_done,
    output sfla_pkg::t_rsp                 o_rsp,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [sfla_pkg::LIMIT_W-1:0]   i_cfg_data
);

    localparam int unsigned PAGE_GRAN   = PAGE_BYTES / 16;
    localparam int unsigned CLS_W       = (CLASS_COUNT > 1) ? $clog2(CLASS_COUNT) : 1;
    localparam int unsigned OFF_W       = $clog2(2 * PAGE_GRAN + 1);
    localparam int unsigned PG_W        = $clog2(POOL_PAGES + 1);
    localparam int unsigned BASE_W      = PG_W + $clog2(PAGE_GRAN);
    localparam int unsigned SIZE_W_PLUS = sfla_pkg::SIZE_W + 1;

    typedef enum logic [2:0] {
        S_IDLE, S_CHECK, S_HEAD, S_CARVE, S_LREAD, S_LWAIT, S_REPLY
    } t_state;

    t_state                        r_state;
    sfla_pkg::t_req                r_req;
    logic [CLS_W-1:0]              r_cls;
    logic                          r_bad;
    logic [sfla_pkg::LINK_W-1:0]   r_heads [0:CLASS_COUNT-1];
    logic [CLASS_COUNT-1:0]        r_hvalid;
    logic [sfla_pkg::LINK_W-1:0]   r_head;
    logic [PG_W-1:0]               r_pages;
    logic [sfla_pkg::LIMIT_W-1:0]  r_limit;
    logic [OFF_W-1:0]              r_off;
    logic [sfla_pkg::GRAN_W-1:0]   r_addr;
    logic                          r_done;
    sfla_pkg::t_rsp                r_rsp;
    sfla_pkg::t_link_wr            n_wr;
    logic [sfla_pkg::GRAN_W-1:0]   n_raddr;
    logic [sfla_pkg::LINK_W-1:0]   w_rdata;
    logic [SIZE_W_PLUS-1:0]        w_cls_full;
    logic [sfla_pkg::GRAN_W-1:0]   w_next;
    logic [OFF_W-1:0]              w_off_sum;
    logic                          w_more;
    logic [PG_W-1:0]               w_usable;
    logic [BASE_W-1:0]             w_base;

    // class = ceil(size / 16)
    assign w_cls_full = SIZE_W_PLUS'((SIZE_W_PLUS'(i_req.req_size) + SIZE_W_PLUS'(15)) >> 4);
    // shared address adder: one entry step
    assign w_next    = r_addr + sfla_pkg::GRAN_W'(r_cls);
    // offset of the entry after next; another entry fits while it stays in the page
    assign w_off_sum = r_off + OFF_W'(r_cls);
    assign w_more    = (w_off_sum <= OFF_W'(PAGE_GRAN));
    assign w_usable  = (32'(r_limit) < POOL_PAGES) ? PG_W'(r_limit) : PG_W'(POOL_PAGES);
    assign w_base    = BASE_W'(r_pages) * BASE_W'(PAGE_GRAN);

    sfla_link_ram u_link (
        .i_clk   (i_clk),
        .i_wr    (n_wr),
        .i_raddr (n_raddr),
        .o_rdata (w_rdata)
    );

    // link store write and read address
    always_comb begin
        n_wr    = '0;
        n_raddr = r_head[sfla_pkg::GRAN_W-1:0];
        case (r_state)
            S_HEAD: begin
                if (r_req.action == sfla_pkg::ACT_FREE) begin
                    n_wr.we   = 1'b1;
                    n_wr.addr = r_req.free_granule;
                    n_wr.data = r_head;
                end
            end
            S_CARVE: begin
                n_wr.we   = 1'b1;
                n_wr.addr = r_addr;
                n_wr.data = w_more ? {1'b1, w_next} : '0;
            end
            default: ;
        endcase
    end

    assign busy        = (r_state != S_IDLE);
    assign o_cfg_ready = (r_state == S_IDLE) && !start;
    assign o_done      = r_done;
    assign o_rsp       = r_rsp;

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done   <= 1'b0;
            r_state  <= S_IDLE;
            r_hvalid <= '0;
            r_pages  <= '0;
            r_limit  <= sfla_pkg::LIMIT_W'(64);
        end else begin
            r_done <= (r_state == S_REPLY);
            case (r_state)
                S_IDLE: begin
                    if (i_cfg_valid && o_cfg_ready) begin
                        r_limit <= i_cfg_data;
                    end
                    if (start) begin
                        r_req   <= i_req;
                        r_cls   <= CLS_W'(w_cls_full);
                        r_bad   <= (w_cls_full == '0) ||
                                   (32'(w_cls_full) >= CLASS_COUNT) ||
                                   (32'(w_cls_full) > PAGE_GRAN);
                        r_state <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    if (r_bad) begin
                        r_rsp   <= '{alloc_granule: '0, status: sfla_pkg::ST_BAD_SIZE};
                        r_state <= S_REPLY;
                    end else begin
                        r_rsp   <= '0;
                        r_head  <= r_hvalid[r_cls] ? r_heads[r_cls] : '0;
                        r_state <= S_HEAD;
                    end
                end
                S_HEAD: begin
                    if (r_req.action == sfla_pkg::ACT_FREE) begin
                        r_heads[r_cls]  <= {1'b1, r_req.free_granule};
                        r_hvalid[r_cls] <= 1'b1;
                        r_state         <= S_REPLY;
                    end else if (r_head[sfla_pkg::LINK_W-1]) begin
                        r_state <= S_LREAD;
                    end else if (r_pages >= w_usable) begin
                        r_rsp.status <= sfla_pkg::ST_NO_PAGES;
                        r_state      <= S_REPLY;
                    end else begin
                        r_addr  <= sfla_pkg::GRAN_W'(w_base);
                        r_head  <= {1'b1, sfla_pkg::GRAN_W'(w_base)};
                        r_off   <= OFF_W'(r_cls);
                        r_pages <= r_pages + PG_W'(1);
                        r_state <= S_CARVE;
                    end
                end
                S_CARVE: begin
                    // advance one entry per cycle
                    r_addr <= w_next;
                    r_off  <= w_off_sum;
                    if (!w_more) begin
                        r_state <= S_LREAD;
                    end
                end
                S_LREAD: begin
                    r_state <= S_LWAIT;
                end
                S_LWAIT: begin
                    r_heads[r_cls]      <= w_rdata;
                    r_hvalid[r_cls]     <= 1'b1;
                    r_rsp.alloc_granule <= r_head[sfla_pkg::GRAN_W-1:0];
                    r_state             <= S_REPLY;
                end
                S_REPLY: begin
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_one_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done) else $error("double done");
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy) else $error("done while busy");
    a_pages: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_pages) <= POOL_PAGES) else $error("page count overflow");

endmodule

>>> rtl/sfla_link_ram.sv
// Link store: one write port, one registered read port.
module sfla_link_ram (
    input  logic                          i_clk,
    input  sfla_pkg::t_link_wr            i_wr,
    input  logic [sfla_pkg::GRAN_W-1:0]   i_raddr,
    output logic [sfla_pkg::LINK_W-1:0]   o_rdata
);

    logic [sfla_pkg::LINK_W-1:0] r_mem [0:(1 << sfla_pkg::GRAN_W)-1];
    logic [sfla_pkg::LINK_W-1:0] r_rdata;

    // write and registered read
    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
